[src/stb_pkg.sv]
// ----------------------------------------------------------------------------
// stb_pkg: shared definitions for the soft timer bank
// Timer count, item kinds, timer stages and the divider handshake types.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MASK_W     = 8;
    localparam int TIME_W     = 32;

    // item kinds
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_START   = 3'd1;
    localparam logic [2:0] KIND_START_P = 3'd2;
    localparam logic [2:0] KIND_STOP    = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT = 3'd4;
    localparam logic [2:0] KIND_TAP     = 3'd5;
    localparam logic [2:0] KIND_ELAPSED = 3'd6;

    // timer stages
    localparam logic [1:0] STAGE_READY = 2'd0;
    localparam logic [1:0] STAGE_REC   = 2'd1;
    localparam logic [1:0] STAGE_DONE  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } div_rsp_t;

endpackage

[src/soft_timer_bank.sv]
// ----------------------------------------------------------------------------
// soft_timer_bank: bank of millisecond one-shot / interval software timers
//
// s_axis carries one command per transfer, its kind on s_tuser: tick, start,
// start with period, stop, timeout query, tap or elapsed query. m_axis returns
// exactly one result per command; fields a command does not answer are zero.
// cfg_we / cfg_wdata write the interval mode mask, one bit per timer.
// Commands are handled one at a time: s_tready is high only while the
// sequencer is idle. An interval timer update runs the timer through a
// shared 32-step divider; a one-shot update compares the elapsed time
// with the period. A tick updates every timer in turn; timeout and tap
// queries update their timer first; start, stop and elapsed act directly.
// The result sits in an output register; while the receiver stalls, the
// finished result waits and no new command is taken.
// A synchronous low aresetn clears the counter, all timers and the mask.
// ----------------------------------------------------------------------------
module soft_timer_bank
    import stb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [MASK_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // timer_index[2:0], new_period_ms[34:3]
    input  logic [2:0]        s_tuser,   // kind[2:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata    // timed_out[0], taps_passed[32:1], elapsed[64:33]
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_AFTER  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [2:0]        kind_reg, kind_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [TIME_W-1:0] np_reg, np_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [TIME_W-1:0] now_reg, now_next;

    logic [TIME_W-1:0] start_reg  [NUM_TIMERS];
    logic [TIME_W-1:0] start_next [NUM_TIMERS];
    logic [1:0]        stage_reg  [NUM_TIMERS];
    logic [1:0]        stage_next [NUM_TIMERS];
    logic [TIME_W-1:0] period_reg [NUM_TIMERS];
    logic [TIME_W-1:0] period_next[NUM_TIMERS];
    logic [TIME_W-1:0] ic_reg     [NUM_TIMERS];
    logic [TIME_W-1:0] ic_next    [NUM_TIMERS];
    logic [TIME_W-1:0] tc_reg     [NUM_TIMERS];
    logic [TIME_W-1:0] tc_next    [NUM_TIMERS];

    logic              res_to_reg, res_to_next;
    logic [TIME_W-1:0] res_tap_reg, res_tap_next;
    logic [TIME_W-1:0] res_el_reg, res_el_next;
    logic              mval_reg, mval_next;
    logic [71:0]       mdata_reg, mdata_next;

    logic [2:0]        s_kind;
    logic [2:0]        s_tix;
    logic [IDX_W-1:0]  s_idx;
    logic [TIME_W-1:0] s_np;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] tap_diff;
    logic              cur_interval;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign s_kind = s_tuser;
    assign s_tix  = s_tdata[2:0];
    assign s_idx  = IDX_W'(s_tix);
    assign s_np   = s_tdata[34:3];

    assign elapsed  = now_reg - start_reg[cur_reg];
    assign tap_diff = ic_reg[cur_reg] - tc_reg[cur_reg];
    // timers beyond the mask width are one-shot
    assign cur_interval = (int'(cur_reg) < MASK_W) ? mask_reg[cur_reg] : 1'b0;

    stb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        cur_next     = cur_reg;
        np_next      = np_reg;
        mask_next    = cfg_we ? cfg_wdata : mask_reg;
        now_next     = now_reg;
        start_next   = start_reg;
        stage_next   = stage_reg;
        period_next  = period_reg;
        ic_next      = ic_reg;
        tc_next      = tc_reg;
        res_to_next  = res_to_reg;
        res_tap_next = res_tap_reg;
        res_el_next  = res_el_reg;
        mval_next    = mval_reg;
        mdata_next   = mdata_reg;
        div_req.start    = 1'b0;
        div_req.dividend = elapsed;
        div_req.divisor  = period_reg[cur_reg];

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next    = s_kind;
                    np_next      = s_np;
                    res_to_next  = 1'b0;
                    res_tap_next = '0;
                    res_el_next  = '0;
                    if (s_kind == KIND_TICK) begin
                        now_next   = now_reg + 1'b1;
                        cur_next   = '0;
                        state_next = ST_UPDATE;
                    end else if (int'(s_tix) < NUM_TIMERS) begin
                        cur_next   = s_idx;
                        state_next = ST_EXEC;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_EXEC: begin
                state_next = ST_RESULT;
                unique case (kind_reg)
                    KIND_START, KIND_START_P: begin
                        if (kind_reg == KIND_START_P) begin
                            period_next[cur_reg] = np_reg;
                        end
                        start_next[cur_reg] = now_reg;
                        stage_next[cur_reg] = STAGE_REC;
                        ic_next[cur_reg]    = '0;
                        tc_next[cur_reg]    = '0;
                    end
                    KIND_STOP: begin
                        start_next[cur_reg] = '0;
                        stage_next[cur_reg] = STAGE_READY;
                    end
                    KIND_TIMEOUT, KIND_TAP: begin
                        state_next = ST_UPDATE;
                    end
                    KIND_ELAPSED: begin
                        res_el_next = elapsed;
                    end
                    default: begin
                    end
                endcase
            end
            ST_UPDATE: begin
                state_next = ST_AFTER;
                if (stage_reg[cur_reg] == STAGE_REC) begin
                    if (cur_interval) begin
                        // zero period leaves the interval count alone
                        if (period_reg[cur_reg] != '0) begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end else if (elapsed >= period_reg[cur_reg]) begin
                        stage_next[cur_reg] = STAGE_DONE;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    ic_next[cur_reg] = div_rsp.quotient;
                    state_next       = ST_AFTER;
                end
            end
            ST_AFTER: begin
                state_next = ST_RESULT;
                priority if (kind_reg == KIND_TICK) begin
                    if (int'(cur_reg) != NUM_TIMERS - 1) begin
                        cur_next   = cur_reg + 1'b1;
                        state_next = ST_UPDATE;
                    end
                end else if (kind_reg == KIND_TIMEOUT) begin
                    res_to_next = (stage_reg[cur_reg] == STAGE_DONE);
                end else begin
                    if (stage_reg[cur_reg] == STAGE_REC && cur_interval
                        && tap_diff != '0) begin
                        tc_next[cur_reg] = ic_reg[cur_reg];
                        res_tap_next     = tap_diff;
                    end
                end
            end
            ST_RESULT: begin
                // wait for the output register to free up
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdata_next = {7'b0, res_el_reg, res_tap_reg, res_to_reg};
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mask_reg  <= '0;
            now_reg   <= '0;
            mval_reg  <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                start_reg[i]  <= '0;
                stage_reg[i]  <= STAGE_READY;
                period_reg[i] <= '0;
                ic_reg[i]     <= '0;
                tc_reg[i]     <= '0;
            end
        end else begin
            state_reg  <= state_next;
            mask_reg   <= mask_next;
            now_reg    <= now_next;
            mval_reg   <= mval_next;
            start_reg  <= start_next;
            stage_reg  <= stage_next;
            period_reg <= period_next;
            ic_reg     <= ic_next;
            tc_reg     <= tc_next;
        end
        kind_reg    <= kind_next;
        cur_reg     <= cur_next;
        np_reg      <= np_next;
        res_to_reg  <= res_to_next;
        res_tap_reg <= res_tap_next;
        res_el_reg  <= res_el_next;
        mdata_reg   <= mdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;

endmodule

[src/stb_div.sv]
// ----------------------------------------------------------------------------
// stb_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse after TIME_W steps.
// ----------------------------------------------------------------------------
module stb_div
    import stb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(TIME_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0] dsr_reg, dsr_next;
    logic [TIME_W:0]   shifted;
    logic [TIME_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[TIME_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            // quotient bits shift in from the bottom as dividend bits leave the top
            if (!diff[TIME_W]) begin
                rem_next = diff[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TIME_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for soft_timer_bank
// Streams directed and random timer commands over s_axis, mirrors the timer
// bank in a local predictor and checks every m_axis result in order. The
// interval mode mask is rewritten between phases while the bank is idle.
// ----------------------------------------------------------------------------
module tb_top
    import stb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_UNUSED    = 3'd7;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         ITEMS_PER_RUN  = 360;

    typedef struct packed {
        logic [31:0] period;
        logic [2:0]  idx;
        logic [2:0]  kind;
    } cmd_t;

    typedef struct packed {
        logic [31:0] elapsed;
        logic [31:0] taps;
        logic        timed_out;
    } reply_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [MASK_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [39:0]       s_tdata   = '0;
    logic [2:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [71:0]       m_tdata;

    soft_timer_bank u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // mirror of the timer bank
    logic [MASK_W-1:0] mode_mask = '0;
    logic [31:0]       tm_now    = '0;
    logic [31:0]       tm_start     [NUM_TIMERS] = '{default: '0};
    logic [1:0]        tm_stage     [NUM_TIMERS] = '{default: STAGE_READY};
    logic [31:0]       tm_period    [NUM_TIMERS] = '{default: '0};
    logic [31:0]       tm_intervals [NUM_TIMERS] = '{default: '0};
    logic [31:0]       tm_taps      [NUM_TIMERS] = '{default: '0};

    cmd_t   pending_cmds [$];
    reply_t replies_due  [$];

    logic s_burst = 1'b0;
    logic m_burst = 1'b0;
    int   send_gap = 0;
    int   hold_cnt = 0;
    int   idle_cycles = 0;
    int   fail_count = 0;
    int   results_seen = 0;
    int   taps_seen = 0;
    int   timeouts_seen = 0;
    int   kind_count [8] = '{default: 0};

    function automatic bit timer_is_interval(int t);
        return (t < MASK_W) && mode_mask[t];
    endfunction

    function automatic void refresh_timer(int t);
        logic [31:0] span;
        if (tm_stage[t] != STAGE_REC)
            return;
        span = tm_now - tm_start[t];
        if (timer_is_interval(t)) begin
            if (tm_period[t] != 0)
                tm_intervals[t] = span / tm_period[t];
        end else if (span >= tm_period[t]) begin
            tm_stage[t] = STAGE_DONE;
        end
    endfunction

    // applies one command to the mirror and returns the answer it produces
    function automatic reply_t timer_bank_answer(cmd_t c);
        reply_t r;
        int t;
        int i;
        logic [31:0] fresh;
        r = '0;
        t = int'(c.idx);
        if (c.kind == KIND_TICK) begin
            tm_now = tm_now + 32'd1;
            for (i = 0; i < NUM_TIMERS; i++)
                refresh_timer(i);
            return r;
        end
        if (t >= NUM_TIMERS)
            return r;
        case (c.kind)
            KIND_START, KIND_START_P: begin
                if (c.kind == KIND_START_P)
                    tm_period[t] = c.period;
                tm_start[t]     = tm_now;
                tm_stage[t]     = STAGE_REC;
                tm_intervals[t] = '0;
                tm_taps[t]      = '0;
            end
            KIND_STOP: begin
                tm_start[t] = '0;
                tm_stage[t] = STAGE_READY;
            end
            KIND_TIMEOUT: begin
                refresh_timer(t);
                r.timed_out = (tm_stage[t] == STAGE_DONE);
            end
            KIND_TAP: begin
                refresh_timer(t);
                if (tm_stage[t] == STAGE_REC && timer_is_interval(t)) begin
                    fresh = tm_intervals[t] - tm_taps[t];
                    if (fresh != 0) begin
                        tm_taps[t] = tm_intervals[t];
                        r.taps     = fresh;
                    end
                end
            end
            KIND_ELAPSED: r.elapsed = tm_now - tm_start[t];
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] kind, logic [2:0] idx,
                                      logic [31:0] period);
        cmd_t c;
        c.kind   = kind;
        c.idx    = idx;
        c.period = period;
        return c;
    endfunction

    // ticks are the commonest kind, between starts and queries, so timers expire and accumulate
    function automatic cmd_t random_cmd();
        cmd_t c;
        int pick;
        int psel;
        pick     = $urandom_range(0, 99);
        psel     = $urandom_range(0, 9);
        c.idx    = 3'($urandom_range(0, 7));
        c.period = $urandom();
        if (pick < 40)      c.kind = KIND_TICK;
        else if (pick < 48) c.kind = KIND_START_P;
        else if (pick < 52) c.kind = KIND_START;
        else if (pick < 56) c.kind = KIND_STOP;
        else if (pick < 70) c.kind = KIND_TIMEOUT;
        else if (pick < 84) c.kind = KIND_TAP;
        else if (pick < 98) c.kind = KIND_ELAPSED;
        else                c.kind = KIND_UNUSED;
        if (c.kind == KIND_START_P) begin
            if (psel < 7)       c.period = 32'($urandom_range(1, 12));
            else if (psel == 7) c.period = '0;
        end
        return c;
    endfunction

    // command driver
    always @(posedge aclk) begin : drive_cmds
        cmd_t nxt;
        int g;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            g = send_gap;
            if (s_tvalid) begin
                nxt = make_cmd(s_tuser, s_tdata[2:0], s_tdata[34:3]);
                replies_due.push_back(timer_bank_answer(nxt));
                kind_count[nxt.kind]++;
                g = s_burst ? 0 : $urandom_range(0, 19);
            end
            if (g == 0 && pending_cmds.size() != 0) begin
                nxt = pending_cmds.pop_front();
                s_tuser  <= nxt.kind;
                s_tdata  <= {5'b00000, nxt.period, nxt.idx};
                s_tvalid <= 1'b1;
                send_gap <= 0;
            end else begin
                s_tvalid <= 1'b0;
                send_gap <= (g > 0) ? g - 1 : 0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : check_results
        reply_t got;
        reply_t want;
        int stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end else if (m_tvalid && m_tready) begin
            got = reply_t'(m_tdata[64:0]);
            results_seen++;
            if (replies_due.size() == 0) begin
                if (fail_count < 10)
                    $display("[%0t] unexpected result: timed_out %0d taps %0d elapsed %0d",
                             $realtime, got.timed_out, got.taps, got.elapsed);
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                if (want.taps != 0)
                    taps_seen++;
                if (want.timed_out)
                    timeouts_seen++;
                if (got !== want) begin
                    if (fail_count < 10) begin
                        $display("[%0t] result %0d mismatch, exp/got:",
                                 $realtime, results_seen);
                        $display("    timed_out %0d/%0d taps %0d/%0d elapsed %0d/%0d",
                                 want.timed_out, got.timed_out, want.taps, got.taps,
                                 want.elapsed, got.elapsed);
                    end
                    fail_count++;
                end
            end
            stall = m_burst ? 0 : $urandom_range(0, 19);
            hold_cnt <= stall;
            m_tready <= (stall == 0);
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= (hold_cnt == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("soft_timer_bank test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || replies_due.size() != 0);
    endtask

    task automatic write_mode_mask(logic [MASK_W-1:0] m);
        wait_drained();
        repeat (4) @(negedge aclk);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        mode_mask = m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        int ph;
        int half;
        int n;
        cmd_t c;
        logic [MASK_W-1:0] m;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: mixed mask, timers 0,2,5,7 interval and 1,3,4,6 one-shot
        write_mode_mask(8'hA5);
        pending_cmds.push_back(make_cmd(KIND_ELAPSED, 3'd0, '0));
        pending_cmds.push_back(make_cmd(KIND_TIMEOUT, 3'd1, '0));
        pending_cmds.push_back(make_cmd(KIND_TAP,     3'd0, '0));
        pending_cmds.push_back(make_cmd(KIND_START_P, 3'd0, 32'd0));
        pending_cmds.push_back(make_cmd(KIND_START_P, 3'd1, 32'd0));
        pending_cmds.push_back(make_cmd(KIND_TIMEOUT, 3'd1, '0));
        pending_cmds.push_back(make_cmd(KIND_START_P, 3'd2, 32'd1));
        pending_cmds.push_back(make_cmd(KIND_START_P, 3'd3, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(KIND_START_P, 3'd7, 32'd2));
        pending_cmds.push_back(make_cmd(KIND_START_P, 3'd4, 32'd3));
        repeat (4) pending_cmds.push_back(make_cmd(KIND_TICK, 3'd7, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(KIND_TAP,     3'd2, '0));
        pending_cmds.push_back(make_cmd(KIND_TAP,     3'd2, '0));
        pending_cmds.push_back(make_cmd(KIND_TAP,     3'd0, '0));
        pending_cmds.push_back(make_cmd(KIND_TAP,     3'd7, '0));
        pending_cmds.push_back(make_cmd(KIND_TIMEOUT, 3'd3, '0));
        pending_cmds.push_back(make_cmd(KIND_TIMEOUT, 3'd4, '0));
        pending_cmds.push_back(make_cmd(KIND_ELAPSED, 3'd3, '0));
        pending_cmds.push_back(make_cmd(KIND_STOP,    3'd2, '0));
        pending_cmds.push_back(make_cmd(KIND_TAP,     3'd2, '0));
        pending_cmds.push_back(make_cmd(KIND_START,   3'd2, '0));
        pending_cmds.push_back(make_cmd(KIND_UNUSED,  3'd7, 32'hFFFF_FFFF));

        // random phases, each under a new mask, extremes included
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       m = 8'hFF;
                1:       m = 8'h00;
                3:       m = 8'h5A;
                default: m = MASK_W'($urandom());
            endcase
            write_mode_mask(m);
            for (half = 0; half < 2; half++) begin
                s_burst = ($urandom_range(0, 3) == 0);
                m_burst = ($urandom_range(0, 3) == 0);
                n = 0;
                while (n < ITEMS_PER_RUN / 2) begin
                    c = random_cmd();
                    pending_cmds.push_back(c);
                    if (c.kind != KIND_UNUSED)
                        n++;
                end
                // sender holds off until the bank has answered everything
                wait_drained();
            end
        end

        wait_drained();
        repeat (300) @(negedge aclk);

        $display("covered %0d ticks, %0d starts, %0d stops, %0d queries, %0d unused kinds",
                 kind_count[KIND_TICK], kind_count[KIND_START] + kind_count[KIND_START_P],
                 kind_count[KIND_STOP],
                 kind_count[KIND_TIMEOUT] + kind_count[KIND_TAP] + kind_count[KIND_ELAPSED],
                 kind_count[KIND_UNUSED]);
        $display("checked %0d results: %0d nonzero tap answers, %0d expired one-shot answers",
                 results_seen, taps_seen, timeouts_seen);
        if (fail_count == 0)
            $display("soft_timer_bank test passed");
        else
            $display("soft_timer_bank test failed");
        $finish;
    end

endmodule

[filelist.f]
src/stb_pkg.sv
src/stb_div.sv
src/soft_timer_bank.sv
test/tb_top.sv
